@@ sv/assert_macros.svh @@
// Assertion macros shared by the point-in-polygon RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PIPIC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define PIPIC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ sv/pipic_pkg.sv @@
// Shared types and constants of the point-in-polygon line classifier.
package pipic_pkg;

	localparam int IDX_W        = 6;
	localparam int COORD_W      = 32;
	localparam int CNT_W        = 16;
	localparam int CLS_W        = 2;
	localparam int VC_W         = 7;
	localparam int IN_DATA_W    = 72;
	localparam int OUT_DATA_W   = 24;
	localparam int MAX_VERTICES_DEF = 64;
	localparam int QUEUE_DEPTH  = 4;

	localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [CLS_W-1:0] CLS_NONE    = 2'd0;
	localparam logic [CLS_W-1:0] CLS_PARTIAL = 2'd1;
	localparam logic [CLS_W-1:0] CLS_ALL     = 2'd2;

	typedef struct packed {
		logic                       kind;
		logic [IDX_W-1:0]           vidx;
		logic signed [COORD_W-1:0]  x;
		logic signed [COORD_W-1:0]  y;
		logic                       last;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

endpackage

@@ sv/pipic_front.sv @@
// Front end: accept items, decode them and drop loads outside the store.
module pipic_front #(
	parameter int MAX_VERTICES = pipic_pkg::MAX_VERTICES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [pipic_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                             s_axis_tuser,
	input  logic                             s_axis_tlast,
	input  pipic_pkg::q_stat_t               q_stat,
	output logic                             push,
	output pipic_pkg::cmd_t                  push_data
);

	logic            hold_valid_q;
	pipic_pkg::cmd_t hold_q;
	pipic_pkg::cmd_t dec;
	logic            accept;
	logic            keep;

	always_comb begin
		dec.kind = s_axis_tuser;
		dec.vidx = s_axis_tdata[5:0];
		dec.x    = s_axis_tdata[37:6];
		dec.y    = s_axis_tdata[69:38];
		dec.last = s_axis_tlast;
	end

	// Loads aimed past the store are dropped here.
	assign keep   = (dec.kind == pipic_pkg::KIND_QUERY) || (32'(dec.vidx) < 32'(MAX_VERTICES));
	assign push   = hold_valid_q && !q_stat.full;
	assign s_axis_tready = !hold_valid_q || push;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign push_data = hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (accept) begin
			hold_valid_q <= keep;
		end else if (push) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hold_q <= dec;
		end
	end

endmodule

@@ sv/pipic_fifo.sv @@
// Short command queue between the front end and the edge walker.
`include "assert_macros.svh"
module pipic_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pipic_pkg::cmd_t    push_data,
	input  logic               pop,
	output pipic_pkg::cmd_t    head,
	output pipic_pkg::q_stat_t stat
);

	localparam int DEPTH = pipic_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	pipic_pkg::cmd_t entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.valid = (count_q != '0);
	assign stat.full  = (count_q == CW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`PIPIC_NEVER(a_no_overflow, push && stat.full && !pop, "push into full queue")
	`PIPIC_NEVER(a_no_underflow, pop && !stat.valid, "pop from empty queue")

endmodule

@@ sv/pipic_back.sv @@
// Back end: vertex store, edge walk pipeline, line counters and result register.
`include "assert_macros.svh"
module pipic_back #(
	parameter int MAX_VERTICES = pipic_pkg::MAX_VERTICES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [pipic_pkg::VC_W-1:0]        vertex_count,
	input  pipic_pkg::q_stat_t                q_stat,
	input  pipic_pkg::cmd_t                   q_head,
	output logic                              pop,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [pipic_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                              m_axis_tlast
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int W  = pipic_pkg::COORD_W;

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN} state_t;

	state_t state_q;

	logic signed [W-1:0] mem_x [MAX_VERTICES];
	logic signed [W-1:0] mem_y [MAX_VERTICES];

	logic [CW-1:0] n_q;
	logic [CW-1:0] rd_idx_q;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_idx32;
	logic [31:0]   vc32;
	logic [31:0]   n32;
	logic          rd_en;

	logic signed [W-1:0] px_q, py_q;
	logic                last_q;
	logic                parity_q;

	logic signed [W-1:0] rx_s1, ry_s1;
	logic                first_s1;
	logic                v_s1;
	logic signed [W-1:0] prev_x_q, prev_y_q;

	logic signed [W:0]   lo_x, lo_y, hi_x, hi_y, pxe, pye;
	logic                live;
	logic signed [W:0]   a_s2, dx_s2, b_s2, dy_s2;
	logic                v_s2;

	logic signed [2*W+1:0] pl_s3, pr_s3;
	logic                  v_s3;

	logic [pipic_pkg::CNT_W-1:0] ins_cnt_q, pt_cnt_q, ins_next, pt_next;
	logic [pipic_pkg::CLS_W-1:0] cls;
	logic                        pipe_empty;

	logic                              out_valid_q;
	logic [pipic_pkg::OUT_DATA_W-1:0]  out_data_q;
	logic                              out_last_q;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	assign pop = (state_q == ST_IDLE) && q_stat.valid &&
		((q_head.kind == pipic_pkg::KIND_LOAD) || !out_valid_q);

	assign vc32     = 32'(vertex_count);
	assign n32      = (vc32 > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : vc32;
	assign wr_idx32 = 32'(q_head.vidx);
	assign wr_addr  = wr_idx32[AW-1:0];
	assign rd_en    = (state_q == ST_WALK);
	// The read one past the last vertex fetches vertex 0 again for the closing edge.
	assign rd_addr  = (rd_idx_q == n_q) ? '0 : rd_idx_q[AW-1:0];
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3;

	// Edge setup: order the endpoints by y and test the half-open span.
	always_comb begin
		pxe = {px_q[W-1], px_q};
		pye = {py_q[W-1], py_q};
		if (prev_y_q > ry_s1) begin
			lo_x = {rx_s1[W-1], rx_s1};
			lo_y = {ry_s1[W-1], ry_s1};
			hi_x = {prev_x_q[W-1], prev_x_q};
			hi_y = {prev_y_q[W-1], prev_y_q};
		end else begin
			lo_x = {prev_x_q[W-1], prev_x_q};
			lo_y = {prev_y_q[W-1], prev_y_q};
			hi_x = {rx_s1[W-1], rx_s1};
			hi_y = {ry_s1[W-1], ry_s1};
		end
		live = v_s1 && !first_s1 && (lo_y != hi_y) && (pye >= lo_y) && (pye < hi_y);
	end

	// Line counters and class for the point that finishes now.
	always_comb begin
		ins_next = (parity_q && (ins_cnt_q != pipic_pkg::COUNT_MAX)) ?
			ins_cnt_q + 16'd1 : ins_cnt_q;
		pt_next  = (pt_cnt_q != pipic_pkg::COUNT_MAX) ? pt_cnt_q + 16'd1 : pt_cnt_q;
		if (!last_q) begin
			cls = pipic_pkg::CLS_NONE;
		end else if (ins_next == '0) begin
			cls = pipic_pkg::CLS_NONE;
		end else if (ins_next == pt_next) begin
			cls = pipic_pkg::CLS_ALL;
		end else begin
			cls = pipic_pkg::CLS_PARTIAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			rd_idx_q    <= '0;
			parity_q    <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			ins_cnt_q   <= '0;
			pt_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= live;
			v_s3 <= v_s2;
			if (v_s3 && (pl_s3 > pr_s3)) begin
				parity_q <= !parity_q;
			end
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop && (q_head.kind == pipic_pkg::KIND_QUERY)) begin
						n_q      <= n32[CW-1:0];
						rd_idx_q <= '0;
						parity_q <= 1'b0;
						state_q  <= ST_WALK;
					end
				end
				ST_WALK: begin
					rd_idx_q <= rd_idx_q + CW'(1);
					if (rd_idx_q == n_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (pipe_empty) begin
						out_valid_q <= 1'b1;
						ins_cnt_q   <= last_q ? '0 : ins_next;
						pt_cnt_q    <= last_q ? '0 : pt_next;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Store and datapath registers.
	always_ff @(posedge clk) begin
		if (pop && (q_head.kind == pipic_pkg::KIND_LOAD)) begin
			mem_x[wr_addr] <= q_head.x;
			mem_y[wr_addr] <= q_head.y;
		end
		if (pop && (q_head.kind == pipic_pkg::KIND_QUERY)) begin
			px_q   <= q_head.x;
			py_q   <= q_head.y;
			last_q <= q_head.last;
		end
		if (rd_en) begin
			rx_s1    <= mem_x[rd_addr];
			ry_s1    <= mem_y[rd_addr];
			first_s1 <= (rd_idx_q == '0);
		end
		if (v_s1) begin
			prev_x_q <= rx_s1;
			prev_y_q <= ry_s1;
		end
		a_s2  <= pye - lo_y;
		dy_s2 <= hi_y - lo_y;
		dx_s2 <= hi_x - lo_x;
		b_s2  <= pxe - lo_x;
		// Crossing lies right of the point when a*dx > b*dy.
		pl_s3 <= (2*W+2)'(a_s2 * dx_s2);
		pr_s3 <= (2*W+2)'(b_s2 * dy_s2);
		if (state_q == ST_DRAIN && pipe_empty) begin
			out_data_q <= {5'b0, cls, ins_next, parity_q};
			out_last_q <= last_q;
		end
	end

	`PIPIC_NEVER(a_busy_out_empty, (state_q != ST_IDLE) && out_valid_q && $past(!out_valid_q) && $past(state_q != ST_IDLE) && (state_q != ST_IDLE), "result raised mid walk")
	`PIPIC_NEVER(a_idle_pipe_empty, (state_q == ST_IDLE) && (v_s2 || v_s3), "edge pipeline busy while idle")
	`PIPIC_ASSERT(a_walk_ends, (state_q == ST_WALK && rd_idx_q == n_q) |=> (state_q == ST_DRAIN), "walk overran")

endmodule

@@ sv/point_in_polygon_line_classifier.sv @@
// Top level of the point-in-polygon line classifier.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      vertex load or query point
//  m_axis    out  m_axis_tvalid/tready      one result per query point
//  cfg       in   cfg_valid/cfg_ready       vertex_count register
//
// A vertex load is written to the store when it leaves the queue. A query
// walks the closed polygon one edge per cycle through a single vertex store
// read port: the item is taken, n+1 reads follow for n vertices in use, then
// the edge pipeline drains and the result register is loaded.
// A query waits in the queue while the previous result sits unaccepted on
// m_axis. Reset is asynchronous, active low; the vertex store needs no
// clearing pass. A four-entry queue lets the input side keep taking items
// while the edge walk runs or a result waits on m_axis.
module point_in_polygon_line_classifier #(
	parameter int MAX_VERTICES = pipic_pkg::MAX_VERTICES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [5:0] vertex_index, [37:6] x_coord, [69:38] y_coord, [71:70] zero
	input  logic [pipic_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// [0] kind
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [0] inside_res, [16:1] inside_count, [18:17] line_class, [23:19] zero
	output logic [pipic_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	output logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pipic_pkg::VC_W-1:0]        cfg_data
);

	logic [pipic_pkg::VC_W-1:0] vertex_count_q;
	logic                       push;
	logic                       pop;
	pipic_pkg::cmd_t            push_data;
	pipic_pkg::cmd_t            q_head;
	pipic_pkg::q_stat_t         q_stat;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			vertex_count_q <= cfg_data;
		end
	end

	pipic_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.q_stat        (q_stat),
		.push          (push),
		.push_data     (push_data)
	);

	pipic_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	pipic_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.vertex_count  (vertex_count_q),
		.q_stat        (q_stat),
		.q_head        (q_head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ test/point_in_polygon_line_checker.sv @@
// Stream monitor that predicts and checks every result of the line classifier.
module point_in_polygon_line_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic [pipic_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	input  logic                              s_axis_tuser,
	input  logic                              s_axis_tlast,
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [pipic_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                              m_axis_tlast,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [pipic_pkg::VC_W-1:0]        cfg_data,
	output int                                failures,
	output int                                pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                        in_poly;
		logic [pipic_pkg::CNT_W-1:0] count;
		logic [pipic_pkg::CLS_W-1:0] cls;
		logic                        done;
	} line_result_t;

	logic signed [pipic_pkg::COORD_W-1:0] poly_x [pipic_pkg::MAX_VERTICES_DEF];
	logic signed [pipic_pkg::COORD_W-1:0] poly_y [pipic_pkg::MAX_VERTICES_DEF];
	logic [pipic_pkg::VC_W-1:0]           poly_count;
	logic [pipic_pkg::CNT_W-1:0]          inside_tally;
	logic [pipic_pkg::CNT_W-1:0]          point_tally;
	line_result_t                         line_results_due [$];

	// Odd number of crossings to the right of the point means inside.
	function automatic logic ray_parity(logic signed [pipic_pkg::COORD_W-1:0] px,
			logic signed [pipic_pkg::COORD_W-1:0] py);
		int n;
		int j;
		logic odd;
		logic signed [67:0] x1, y1, x2, y2, t, lhs, rhs, qx, qy;
		n = (poly_count > pipic_pkg::MAX_VERTICES_DEF) ? pipic_pkg::MAX_VERTICES_DEF
			: int'(poly_count);
		odd = 1'b0;
		qx = px;
		qy = py;
		for (int i = 0; i < n; i++) begin
			j = (i + 1 == n) ? 0 : i + 1;
			x1 = poly_x[i];
			y1 = poly_y[i];
			x2 = poly_x[j];
			y2 = poly_y[j];
			if (y1 == y2)
				continue;
			if (y1 > y2) begin
				t = x1; x1 = x2; x2 = t;
				t = y1; y1 = y2; y2 = t;
			end
			if (qy < y1 || qy >= y2)
				continue;
			lhs = (qy - y1) * (x2 - x1);
			rhs = (qx - x1) * (y2 - y1);
			if (lhs > rhs)
				odd = ~odd;
		end
		return odd;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		line_result_t want, got;
		logic hit;
		logic [pipic_pkg::CNT_W-1:0] pt_next;
		if (!arst_n) begin
			poly_count   <= '0;
			inside_tally <= '0;
			point_tally  <= '0;
			failures     <= 0;
			pending      <= 0;
			line_results_due.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[0], m_axis_tdata[16:1], m_axis_tdata[18:17], m_axis_tlast};
				if (line_results_due.size() == 0) begin
					if (failures < 10)
						$display("%0t: result with none due: %p", $realtime, got);
					failures <= failures + 1;
				end else begin
					want = line_results_due.pop_front();
					if (want !== got) begin
						if (failures < 10)
							$display("%0t: expected %p, got %p", $realtime, want, got);
						failures <= failures + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				poly_count <= cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser == pipic_pkg::KIND_LOAD) begin
					poly_x[s_axis_tdata[5:0]] <= s_axis_tdata[37:6];
					poly_y[s_axis_tdata[5:0]] <= s_axis_tdata[69:38];
				end else begin
					hit = ray_parity(s_axis_tdata[37:6], s_axis_tdata[69:38]);
					pt_next = (point_tally != pipic_pkg::COUNT_MAX) ?
						point_tally + 16'd1 : point_tally;
					want.in_poly = hit;
					want.count   = (hit && inside_tally != pipic_pkg::COUNT_MAX) ?
						inside_tally + 16'd1 : inside_tally;
					want.done    = s_axis_tlast;
					want.cls     = pipic_pkg::CLS_NONE;
					if (s_axis_tlast && want.count != '0)
						want.cls = (want.count == pt_next) ? pipic_pkg::CLS_ALL
							: pipic_pkg::CLS_PARTIAL;
					line_results_due.insert(line_results_due.size(), want);
					if (s_axis_tlast) begin
						inside_tally <= '0;
						point_tally  <= '0;
					end else begin
						inside_tally <= want.count;
						point_tally  <= pt_next;
					end
				end
			end
			pending <= line_results_due.size();
		end
	end

endmodule

@@ test/point_in_polygon_line_classifier_test.sv @@
// Stimulus and verdict for the point-in-polygon line classifier.
module point_in_polygon_line_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 6000;

	logic                                clk;
	logic                                arst_n;
	logic                                s_axis_tvalid;
	logic                                s_axis_tready;
	// [5:0] vertex_index, [37:6] x_coord, [69:38] y_coord, [71:70] zero
	logic [pipic_pkg::IN_DATA_W-1:0]     s_axis_tdata;
	// [0] kind
	logic                                s_axis_tuser;
	logic                                s_axis_tlast;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready;
	// [0] inside_res, [16:1] inside_count, [18:17] line_class, [23:19] zero
	logic [pipic_pkg::OUT_DATA_W-1:0]    m_axis_tdata;
	logic                                m_axis_tlast;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [pipic_pkg::VC_W-1:0]          cfg_data;
	int                                  failures;
	int                                  pending;
	int                                  quiet_cycles;
	// Gaps are off during burst stretches so back-to-back items also occur.
	logic                                burst;

	// Top-side copy of the polygon, used to aim query points at its corners.
	logic signed [pipic_pkg::COORD_W-1:0] corner_x [pipic_pkg::MAX_VERTICES_DEF];
	logic signed [pipic_pkg::COORD_W-1:0] corner_y [pipic_pkg::MAX_VERTICES_DEF];
	int                                   corner_n;

	point_in_polygon_line_classifier uut (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
		.cfg_valid, .cfg_ready, .cfg_data
	);

	point_in_polygon_line_checker u_checker (
		.clk, .arst_n,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
		.cfg_valid, .cfg_ready, .cfg_data,
		.failures, .pending
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Send one item: idle a random gap, then hold it until accepted.
	// Entered and left at a falling edge; valid stays high across zero gaps.
	task automatic send_item(logic kind, logic [pipic_pkg::IDX_W-1:0] idx,
			logic signed [pipic_pkg::COORD_W-1:0] x,
			logic signed [pipic_pkg::COORD_W-1:0] y, logic last);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tlast  = last;
		s_axis_tdata  = {2'b00, y, x, idx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic load_corner(int i, logic signed [pipic_pkg::COORD_W-1:0] x,
			logic signed [pipic_pkg::COORD_W-1:0] y);
		corner_x[i] = x;
		corner_y[i] = y;
		send_item(pipic_pkg::KIND_LOAD, i[pipic_pkg::IDX_W-1:0], x, y, 1'b0);
	endtask

	// Write vertex_count only once the block has drained: no result due and
	// a pause long enough for a trailing load or edge walk to finish.
	task automatic set_vertex_count(logic [pipic_pkg::VC_W-1:0] value);
		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		corner_n = (value > pipic_pkg::MAX_VERTICES_DEF) ? pipic_pkg::MAX_VERTICES_DEF
			: int'(value);
	endtask

	function automatic logic signed [pipic_pkg::COORD_W-1:0] pick_coord(int span,
			logic signed [pipic_pkg::COORD_W-1:0] near);
		case ($urandom_range(0, 5))
			0:       return $urandom;
			1:       return near;
			2:       return near + $signed($urandom_range(0, 4)) - 2;
			default: return $signed($urandom_range(0, 2 * span)) - span;
		endcase
	endfunction

	// Load a random polygon of n corners within +/- span, or anywhere when span is 0; some edges flat.
	task automatic load_polygon(int n, int span);
		logic signed [pipic_pkg::COORD_W-1:0] x, y;
		for (int i = 0; i < n; i++) begin
			x = (span == 0) ? $urandom : $signed($urandom_range(0, 2 * span)) - span;
			y = (span == 0) ? $urandom : $signed($urandom_range(0, 2 * span)) - span;
			if (i > 0 && $urandom_range(0, 3) == 0)
				y = corner_y[i - 1];
			load_corner(i, x, y);
		end
	endtask

	// Random lines of query points, with the odd vertex load mid-line.
	task automatic run_lines(int points, int span);
		int left;
		int k;
		logic signed [pipic_pkg::COORD_W-1:0] x, y;
		left = points;
		while (left > 0) begin
			k = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 9);
			for (int p = 0; p < k && left > 0; p++) begin
				if (corner_n > 0 && $urandom_range(0, 24) == 0) begin
					// overwrite a live corner in the middle of a line
					load_corner($urandom_range(0, corner_n - 1), pick_coord(span, 0),
						pick_coord(span, 0));
				end
				if (corner_n > 0 && $urandom_range(0, 2) == 0) begin
					x = pick_coord(span, corner_x[$urandom_range(0, corner_n - 1)]);
					y = pick_coord(span, corner_y[$urandom_range(0, corner_n - 1)]);
				end else begin
					x = pick_coord(span, 0);
					y = pick_coord(span, 0);
				end
				send_item(pipic_pkg::KIND_QUERY, 6'($urandom), x, y,
					(p == k - 1) || (left == 1));
				left--;
			end
			if ($urandom_range(0, 15) == 0)
				burst = ~burst;
		end
	endtask

	// Count cycles with no handshake on any channel; end a hung run.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("point_in_polygon_line_classifier: mismatch");
			$finish;
		end
	end

	// Stall the result side at random, with stretches of no stall.
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				m_axis_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready = 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		int counts [10];
		quiet_cycles  = 0;
		burst         = 1'b0;
		corner_n      = 0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = pipic_pkg::KIND_LOAD;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill the whole store first so no later walk reads an unwritten slot.
		burst = 1'b1;
		load_polygon(pipic_pkg::MAX_VERTICES_DEF, 0);
		burst = 1'b0;

		// Directed: an axis-aligned square, points inside, on each side, at
		// the coordinate extremes, and lines that are all, partly, none inside.
		set_vertex_count(7'd4);
		load_corner(0, -100, -100);
		load_corner(1,  100, -100);
		load_corner(2,  100,  100);
		load_corner(3, -100,  100);
		send_item(pipic_pkg::KIND_QUERY, 6'd0,    0,    0, 1'b0);
		send_item(pipic_pkg::KIND_QUERY, 6'd63,  10,  -10, 1'b1);
		send_item(pipic_pkg::KIND_QUERY, 6'd0, -100,    0, 1'b0);
		send_item(pipic_pkg::KIND_QUERY, 6'd0,  100,    0, 1'b0);
		send_item(pipic_pkg::KIND_QUERY, 6'd0,    0, -100, 1'b0);
		send_item(pipic_pkg::KIND_QUERY, 6'd0,    0,  100, 1'b1);
		send_item(pipic_pkg::KIND_QUERY, 6'd0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
		send_item(pipic_pkg::KIND_QUERY, 6'd0, 32'sh80000000, 32'sh80000000, 1'b1);
		send_item(pipic_pkg::KIND_QUERY, 6'd0,   99,   99, 1'b0);
		// a load mid-line leaves the line counters alone
		load_corner(2, 200, 100);
		send_item(pipic_pkg::KIND_QUERY, 6'd0,  150,   50, 1'b0);
		send_item(pipic_pkg::KIND_QUERY, 6'd0,  500,   50, 1'b1);
		// corners at the extremes of the coordinate range
		load_corner(0, 32'sh80000000, 32'sh80000000);
		load_corner(1, 32'sh7FFFFFFF, 32'sh80000000);
		load_corner(2, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		load_corner(3, 32'sh80000000, 32'sh7FFFFFFF);
		send_item(pipic_pkg::KIND_QUERY, 6'd0, 0, 0, 1'b0);
		send_item(pipic_pkg::KIND_QUERY, 6'd0, 32'sh80000000, 32'sh80000000, 1'b0);
		send_item(pipic_pkg::KIND_QUERY, 6'd0, 32'sh7FFFFFFE, 32'sh7FFFFFFE, 1'b1);

		// Random phases: degenerate, small, full store and counts above it.
		counts = '{0, 1, 2, 3, 5, 64, 100, 127, 8, 0};
		counts[8] = $urandom_range(3, 20);
		counts[9] = $urandom_range(4, 12);
		for (int ph = 0; ph < 10; ph++) begin
			set_vertex_count(7'(counts[ph]));
			load_polygon(corner_n, (ph == 9) ? 0 : 200);
			run_lines(60, (ph == 9) ? 1000000 : 250);
		end

		s_axis_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (100) @(posedge clk);
		if (failures == 0)
			$display("point_in_polygon_line_classifier: match");
		else
			$display("point_in_polygon_line_classifier: mismatch");
		$finish;
	end

endmodule
